// ===== rtl/core/sfp_pkg.sv =====
// shared types and constants of the sync and frame parser
package sfp_pkg;

   // parser phase, one-hot
   typedef enum logic [4:0] {
      PH_IDLE    = 5'b00001,
      PH_COUNT   = 5'b00010,
      PH_WAIT_FE = 5'b00100,
      PH_HEADER  = 5'b01000,
      PH_DATA    = 5'b10000
   } phase_type;

   // position within the four-byte header
   localparam logic [1:0] HDR_START   = 2'd0;
   localparam logic [1:0] HDR_ID      = 2'd1;
   localparam logic [1:0] HDR_LEN_LOW = 2'd2;
   localparam logic [1:0] HDR_LEN_HI  = 2'd3;

   // error codes on the result
   localparam logic [1:0] ERR_NONE      = 2'd0;
   localparam logic [1:0] ERR_BAD_START = 2'd1;
   localparam logic [1:0] ERR_BAD_ID    = 2'd2;
   localparam logic [1:0] ERR_BAD_LEN   = 2'd3;

   // link bytes
   localparam logic [7:0] BYTE_FF = 8'hFF;
   localparam logic [7:0] BYTE_FE = 8'hFE;

   // command codes
   localparam logic CMD_BYTE  = 1'b0;
   localparam logic CMD_START = 1'b1;

   // configuration register indexes
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DATA_W = 9;
   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_RUN   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ID_FIRST   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ID_SECOND  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ID_THIRD   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LEN_FIRST  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LEN_SECOND = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_LEN_THIRD  = 3'd6;

   // register reset values
   localparam logic [7:0] RST_SYNC_RUN   = 8'd50;
   localparam logic [7:0] RST_ID_FIRST   = 8'd17;
   localparam logic [7:0] RST_ID_SECOND  = 8'd18;
   localparam logic [7:0] RST_ID_THIRD   = 8'd19;
   localparam logic [8:0] RST_LEN_FIRST  = 9'd4;
   localparam logic [8:0] RST_LEN_SECOND = 9'd256;
   localparam logic [8:0] RST_LEN_THIRD  = 9'd12;

   // run counter saturation point
   localparam logic [7:0] RUN_MAX = 8'd255;

endpackage

// ===== rtl/core/sync_and_frame_parser.sv =====
// link sync handshake and length-prefixed frame parser, one byte per item
// an accepted item reaches its result through the input register and then the result register
// throughput: one item per cycle while results are taken, limited by the single-pass state update
// each item gives exactly one result; the input side keeps taking items while
// the result register is free or being emptied in the same cycle
// reset: synchronous, active high; phase idle, not synced, registers at defaults
module sync_and_frame_parser #(
   parameter int unsigned MAX_PAYLOAD = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   // input channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_command,
   input  logic [7:0]                        req_rx_byte,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_tx_valid,
   output logic [7:0]                        rsp_tx_byte,
   output logic                              rsp_payload_valid,
   output logic [7:0]                        rsp_payload_byte,
   output logic                              rsp_payload_last,
   output logic [7:0]                        rsp_frame_id,
   output logic [1:0]                        rsp_error_code,
   output logic                              rsp_link_synced,
   // configuration port
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [sfp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [sfp_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int unsigned LEN_W = $clog2(MAX_PAYLOAD + 1);
   localparam logic [15:0] MAX_LEN = 16'(MAX_PAYLOAD);

   // configuration registers
   logic [7:0] sync_run_ff;
   logic [7:0] id_first_ff, id_second_ff, id_third_ff;
   logic [8:0] len_first_ff, len_second_ff, len_third_ff;

   // input register
   logic       in_valid_ff;
   logic       in_command_ff;
   logic [7:0] in_byte_ff;

   // parser state
   sfp_pkg::phase_type phase_ff, phase_in;
   logic [1:0]         hdr_idx_ff, hdr_idx_in;
   logic [7:0]         held_id_ff, held_id_in;
   logic [7:0]         len_low_ff, len_low_in;
   logic [LEN_W-1:0]   pay_len_ff, pay_len_in;
   logic [LEN_W-1:0]   pay_cnt_ff, pay_cnt_in;
   logic [7:0]         run_cnt_ff, run_cnt_in;

   // result register
   logic       out_valid_ff;
   logic       tx_valid_ff, tx_valid_in;
   logic [7:0] tx_byte_ff, tx_byte_in;
   logic       pay_valid_ff, pay_valid_in;
   logic [7:0] pay_byte_ff, pay_byte_in;
   logic       pay_last_ff, pay_last_in;
   logic [7:0] frame_id_ff, frame_id_in;
   logic [1:0] err_ff, err_in;
   logic       synced_ff, synced_in;

   logic             advance;
   logic [15:0]      hdr_len;
   logic             id_ok;
   logic             len_ok;
   logic [7:0]       run_inc;
   logic [LEN_W-1:0] cnt_inc;

   // handshakes
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;

   // header checks
   assign hdr_len = {in_byte_ff, len_low_ff};
   assign id_ok   = (held_id_ff == id_first_ff) || (held_id_ff == id_second_ff)
                    || (held_id_ff == id_third_ff);
   assign len_ok  = (hdr_len != 16'd0) && (hdr_len <= MAX_LEN)
                    && ((hdr_len == {7'd0, len_first_ff})
                        || (hdr_len == {7'd0, len_second_ff})
                        || (hdr_len == {7'd0, len_third_ff}));
   assign run_inc = (run_cnt_ff < sfp_pkg::RUN_MAX) ? run_cnt_ff + 8'd1 : run_cnt_ff;
   assign cnt_inc = pay_cnt_ff + LEN_W'(1);

   // single-pass next state and result
   always_comb begin
      phase_in     = phase_ff;
      hdr_idx_in   = hdr_idx_ff;
      held_id_in   = held_id_ff;
      len_low_in   = len_low_ff;
      pay_len_in   = pay_len_ff;
      pay_cnt_in   = pay_cnt_ff;
      run_cnt_in   = run_cnt_ff;
      tx_valid_in  = 1'b0;
      tx_byte_in   = 8'd0;
      pay_valid_in = 1'b0;
      pay_byte_in  = 8'd0;
      pay_last_in  = 1'b0;
      frame_id_in  = 8'd0;
      err_in       = sfp_pkg::ERR_NONE;
      if (in_command_ff == sfp_pkg::CMD_START) begin
         tx_valid_in = 1'b1;
         tx_byte_in  = sfp_pkg::BYTE_FF;
         phase_in    = sfp_pkg::PH_COUNT;
         run_cnt_in  = 8'd0;
         hdr_idx_in  = sfp_pkg::HDR_START;
         pay_cnt_in  = '0;
      end else begin
         unique case (phase_ff)
            sfp_pkg::PH_COUNT: begin
               if (in_byte_ff == sfp_pkg::BYTE_FF) begin
                  run_cnt_in = run_inc;
                  if (run_inc >= sync_run_ff) begin
                     tx_valid_in = 1'b1;
                     tx_byte_in  = sfp_pkg::BYTE_FE;
                     phase_in    = sfp_pkg::PH_WAIT_FE;
                  end
               end else begin
                  run_cnt_in = 8'd0;
               end
            end
            sfp_pkg::PH_WAIT_FE: begin
               if (in_byte_ff == sfp_pkg::BYTE_FE) begin
                  phase_in   = sfp_pkg::PH_HEADER;
                  hdr_idx_in = sfp_pkg::HDR_START;
               end
            end
            sfp_pkg::PH_HEADER: begin
               unique case (hdr_idx_ff)
                  sfp_pkg::HDR_START: begin
                     if (in_byte_ff == sfp_pkg::BYTE_FF) begin
                        hdr_idx_in = sfp_pkg::HDR_ID;
                     end else begin
                        err_in = sfp_pkg::ERR_BAD_START;
                     end
                  end
                  sfp_pkg::HDR_ID: begin
                     held_id_in = in_byte_ff;
                     hdr_idx_in = sfp_pkg::HDR_LEN_LOW;
                  end
                  sfp_pkg::HDR_LEN_LOW: begin
                     len_low_in = in_byte_ff;
                     hdr_idx_in = sfp_pkg::HDR_LEN_HI;
                  end
                  sfp_pkg::HDR_LEN_HI: begin
                     hdr_idx_in = sfp_pkg::HDR_START;
                     priority if (!id_ok) begin
                        err_in      = sfp_pkg::ERR_BAD_ID;
                        frame_id_in = held_id_ff;
                     end else if (!len_ok) begin
                        err_in      = sfp_pkg::ERR_BAD_LEN;
                        frame_id_in = held_id_ff;
                     end else begin
                        // length checked against the limit, so it fits
                        pay_len_in = hdr_len[LEN_W-1:0];
                        pay_cnt_in = '0;
                        phase_in   = sfp_pkg::PH_DATA;
                     end
                  end
                  default: begin
                     hdr_idx_in = sfp_pkg::HDR_START;
                  end
               endcase
            end
            sfp_pkg::PH_DATA: begin
               pay_valid_in = 1'b1;
               pay_byte_in  = in_byte_ff;
               frame_id_in  = held_id_ff;
               pay_cnt_in   = cnt_inc;
               if (cnt_inc >= pay_len_ff) begin
                  pay_last_in = 1'b1;
                  pay_cnt_in  = '0;
                  phase_in    = sfp_pkg::PH_HEADER;
                  hdr_idx_in  = sfp_pkg::HDR_START;
               end
            end
            default: begin
               // idle, and any stray code, ignores bytes
               phase_in = sfp_pkg::PH_IDLE;
            end
         endcase
      end
      synced_in = (phase_in == sfp_pkg::PH_HEADER) || (phase_in == sfp_pkg::PH_DATA);
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         sync_run_ff   <= sfp_pkg::RST_SYNC_RUN;
         id_first_ff   <= sfp_pkg::RST_ID_FIRST;
         id_second_ff  <= sfp_pkg::RST_ID_SECOND;
         id_third_ff   <= sfp_pkg::RST_ID_THIRD;
         len_first_ff  <= sfp_pkg::RST_LEN_FIRST;
         len_second_ff <= sfp_pkg::RST_LEN_SECOND;
         len_third_ff  <= sfp_pkg::RST_LEN_THIRD;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            sfp_pkg::CSR_SYNC_RUN:   sync_run_ff   <= csr_data[7:0];
            sfp_pkg::CSR_ID_FIRST:   id_first_ff   <= csr_data[7:0];
            sfp_pkg::CSR_ID_SECOND:  id_second_ff  <= csr_data[7:0];
            sfp_pkg::CSR_ID_THIRD:   id_third_ff   <= csr_data[7:0];
            sfp_pkg::CSR_LEN_FIRST:  len_first_ff  <= csr_data;
            sfp_pkg::CSR_LEN_SECOND: len_second_ff <= csr_data;
            sfp_pkg::CSR_LEN_THIRD:  len_third_ff  <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         in_command_ff <= req_command;
         in_byte_ff    <= req_rx_byte;
      end
   end

   // parser state, moves when an item passes to the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= sfp_pkg::PH_IDLE;
         hdr_idx_ff <= sfp_pkg::HDR_START;
         held_id_ff <= 8'd0;
         len_low_ff <= 8'd0;
         pay_len_ff <= '0;
         pay_cnt_ff <= '0;
         run_cnt_ff <= 8'd0;
      end else if (advance) begin
         phase_ff   <= phase_in;
         hdr_idx_ff <= hdr_idx_in;
         held_id_ff <= held_id_in;
         len_low_ff <= len_low_in;
         pay_len_ff <= pay_len_in;
         pay_cnt_ff <= pay_cnt_in;
         run_cnt_ff <= run_cnt_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
      if (advance) begin
         tx_valid_ff  <= tx_valid_in;
         tx_byte_ff   <= tx_byte_in;
         pay_valid_ff <= pay_valid_in;
         pay_byte_ff  <= pay_byte_in;
         pay_last_ff  <= pay_last_in;
         frame_id_ff  <= frame_id_in;
         err_ff       <= err_in;
         synced_ff    <= synced_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_tx_valid      = tx_valid_ff;
   assign rsp_tx_byte       = tx_byte_ff;
   assign rsp_payload_valid = pay_valid_ff;
   assign rsp_payload_byte  = pay_byte_ff;
   assign rsp_payload_last  = pay_last_ff;
   assign rsp_frame_id      = frame_id_ff;
   assign rsp_error_code    = err_ff;
   assign rsp_link_synced   = synced_ff;

   // payload counter never reaches the frame length while streaming
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == sfp_pkg::PH_DATA) |-> (pay_cnt_ff < pay_len_ff))
      else $error("payload count reached frame length inside a frame");

   // a payload byte is only delivered on a synced link
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && pay_valid_ff) |-> synced_ff)
      else $error("payload byte while link not synced");

   // a transmit request never coincides with a payload byte or an error
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && tx_valid_ff) |-> (!pay_valid_ff && err_ff == sfp_pkg::ERR_NONE))
      else $error("transmit request mixed with payload or error");

   // the parser state only moves when an item passes through
   assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(phase_ff))
      else $error("phase changed without an item");

endmodule
